@@ sv/wdft_pkg.sv @@
// wdft_pkg: shared types, constants and the sine table function for the windowed dft bank
// no dependencies; used by the controller, datapath, top level and checker by scoped names
package wdft_pkg;

	localparam int MAX_FRAME_DEF       = 1024;
	localparam int MAX_FREQS_DEF       = 64;
	localparam int SINE_INDEX_BITS_DEF = 10;

	localparam int FRAME_LEN_W = 11;
	localparam int HOP_W       = 11;
	localparam int FREQ_CNT_W  = 7;
	localparam int SLOT_W      = 10;
	localparam int SAMPLE_W    = 16;
	localparam int WEIGHT_W    = 16;
	localparam int STEP_W      = 24;
	localparam int FRAME_NUM_W = 16;
	localparam int FREQ_NUM_W  = 6;
	localparam int ACC_W       = 48;
	localparam int TRIG_W      = 16;
	localparam int CFG_IDX_W   = 2;

	typedef enum logic [1:0] {
		CMD_WEIGHT = 2'd0,
		CMD_STEP   = 2'd1,
		CMD_SAMPLE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_LEN = 2'd0,
		REG_HOP       = 2'd1,
		REG_FREQ_CNT  = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]                 command;
		logic [SLOT_W-1:0]          slot;
		logic signed [SAMPLE_W-1:0] sample;
		logic [WEIGHT_W-1:0]        weight;
		logic [STEP_W-1:0]          phase_step;
	} in_item_t;

	typedef struct packed {
		logic [FRAME_NUM_W-1:0]  frame_number;
		logic [FREQ_NUM_W-1:0]   freq_number;
		logic signed [ACC_W-1:0] cos_sum;
		logic signed [ACC_W-1:0] sin_sum;
		logic                    last;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear;
		logic issue;
	} dp_cmd_t;

	// quarter-wave sine in q15, integer taylor series, evaluated at elaboration
	// qbits is log2 of the quarter-wave length
	function automatic logic [TRIG_W-1:0] quarter_sine(input int m, input int qbits);
		logic [127:0] x, x2, term, pos, neg, s;
		int k;
		x = (128'(m) * 128'd3373259426) >> (qbits + 1);
		x2 = (x * x) >> 30;
		term = x;
		pos = x;
		neg = '0;
		for (k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / 128'((2 * k) * (2 * k + 1));
			if ((k & 1) != 0) neg = neg + term;
			else pos = pos + term;
		end
		s = (pos > neg) ? pos - neg : '0;
		s = (s + 128'd16384) >> 15;
		if (s > 128'd32767) s = 128'd32767;
		return s[TRIG_W-1:0];
	endfunction

endpackage

@@ sv/wdft_ram.sv @@
// wdft_ram: generic single-port-write, single-read ram with registered read data
// no dependencies
module wdft_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ sv/wdft_datapath.sv @@
// wdft_datapath: tables, sample ring, phase accumulator, sine rom and shared mac
// depends on wdft_pkg and wdft_ram
module wdft_datapath #(
	parameter int MAX_FRAME       = wdft_pkg::MAX_FRAME_DEF,
	parameter int MAX_FREQS       = wdft_pkg::MAX_FREQS_DEF,
	parameter int SINE_INDEX_BITS = wdft_pkg::SINE_INDEX_BITS_DEF,
	localparam int AW = $clog2(MAX_FRAME),
	localparam int FW = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wdft_pkg::in_item_t               in_item,
	input  logic                             weight_we,
	input  logic                             step_we,
	input  logic                             sample_we,
	input  logic [AW-1:0]                    wr_ptr,
	input  wdft_pkg::dp_cmd_t                cmd,
	input  logic [AW-1:0]                    tap,
	input  logic [AW-1:0]                    ring_pos,
	input  logic [FW-1:0]                    freq_idx,
	output logic signed [wdft_pkg::ACC_W-1:0] cos_acc,
	output logic signed [wdft_pkg::ACC_W-1:0] sin_acc,
	output logic                             busy
);
	localparam int QUARTER  = 1 << (SINE_INDEX_BITS - 2);
	localparam int QW       = SINE_INDEX_BITS - 2;
	localparam int SW       = wdft_pkg::SAMPLE_W;
	localparam int TW       = wdft_pkg::TRIG_W;
	localparam int STW      = wdft_pkg::STEP_W;
	localparam int AC       = wdft_pkg::ACC_W;

	logic [SW-1:0]  samp_rd;
	logic [SW-1:0]  wgt_rd;
	logic [STW-1:0] step_rd;
	logic [STW-1:0] phase_q;

	wdft_ram #(.WIDTH(SW), .DEPTH(MAX_FRAME)) u_ring (
		.clk(clk), .we(sample_we), .waddr(wr_ptr), .wdata(in_item.sample),
		.raddr(ring_pos), .rdata(samp_rd));

	wdft_ram #(.WIDTH(SW), .DEPTH(MAX_FRAME)) u_weights (
		.clk(clk), .we(weight_we), .waddr(AW'(in_item.slot)), .wdata(in_item.weight),
		.raddr(tap), .rdata(wgt_rd));

	wdft_ram #(.WIDTH(STW), .DEPTH(MAX_FREQS)) u_steps (
		.clk(clk), .we(step_we), .waddr(FW'(in_item.slot)), .wdata(in_item.phase_step),
		.raddr(freq_idx), .rdata(step_rd));

	// phase accumulator, phase is tap * step mod 2^24
	// the step read data is valid from the first tap and holds while freq_idx holds
	always_ff @(posedge clk) begin
		if (cmd.clear) phase_q <= '0;
		else if (cmd.issue) phase_q <= phase_q + step_rd;
	end

	// stage 1: rom lookup alongside the memory reads
	logic [SINE_INDEX_BITS-1:0] sidx, cidx;
	logic signed [TW-1:0] sin_s1, cos_s1;
	logic [TW-1:0] quarter_rom [QUARTER+1];

	always_comb begin
		for (int m = 0; m <= QUARTER; m++) quarter_rom[m] = wdft_pkg::quarter_sine(m, QW);
	end

	function automatic logic signed [TW-1:0] rom_sine(input logic [SINE_INDEX_BITS-1:0] i,
			input logic [TW-1:0] rom [QUARTER+1]);
		logic [QW-1:0] r;
		logic [QW:0]   a;
		logic [TW-1:0] v;
		r = i[QW-1:0];
		a = i[QW] ? (QW+1)'(QUARTER) - {1'b0, r} : {1'b0, r};
		v = rom[a];
		return i[QW+1] ? -$signed(v) : $signed(v);
	endfunction

	assign sidx = phase_q[STW-1 -: SINE_INDEX_BITS];
	assign cidx = sidx + SINE_INDEX_BITS'(QUARTER);

	logic v_s1, v_s2, v_s3;
	always_ff @(posedge clk) begin
		sin_s1 <= rom_sine(sidx, quarter_rom);
		cos_s1 <= rom_sine(cidx, quarter_rom);
	end

	// stage 2: windowed sample, floor shift by 15
	logic signed [SW+1:0] wv_s2;
	logic signed [TW-1:0] sin_s2, cos_s2;
	logic signed [SW+16:0] prod;
	assign prod = $signed(samp_rd) * $signed({1'b0, wgt_rd});
	always_ff @(posedge clk) begin
		wv_s2  <= prod[SW+16:15];
		sin_s2 <= sin_s1;
		cos_s2 <= cos_s1;
	end

	// stage 3: trig products
	logic signed [SW+TW+1:0] cp_s3, sp_s3;
	always_ff @(posedge clk) begin
		cp_s3 <= wv_s2 * cos_s2;
		sp_s3 <= wv_s2 * sin_s2;
	end

	// valid chain for the mac pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	// accumulate, wrapping at 48 bits
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			cos_acc <= '0;
			sin_acc <= '0;
		end else if (v_s3) begin
			cos_acc <= cos_acc + AC'(cp_s3);
			sin_acc <= sin_acc + AC'(sp_s3);
		end
	end

	assign busy = v_s1 | v_s2 | v_s3;
endmodule

@@ sv/wdft_ctrl.sv @@
// wdft_ctrl: controller; input handling, window and hop counting, tap and frequency sequencing
// depends on wdft_pkg
module wdft_ctrl #(
	parameter int MAX_FRAME = wdft_pkg::MAX_FRAME_DEF,
	parameter int MAX_FREQS = wdft_pkg::MAX_FREQS_DEF,
	localparam int AW = $clog2(MAX_FRAME),
	localparam int FW = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  wdft_pkg::in_item_t                   in_item,
	input  logic [wdft_pkg::FRAME_LEN_W-1:0]     frame_length,
	input  logic [wdft_pkg::HOP_W-1:0]           hop_size,
	input  logic [wdft_pkg::FREQ_CNT_W-1:0]      freq_count,
	output logic                                 weight_we,
	output logic                                 step_we,
	output logic                                 sample_we,
	output logic [AW-1:0]                        wr_ptr,
	output wdft_pkg::dp_cmd_t                    cmd,
	output logic [AW-1:0]                        tap,
	output logic [AW-1:0]                        ring_pos,
	output logic [FW-1:0]                        freq_idx,
	input  logic                                 busy,
	input  logic signed [wdft_pkg::ACC_W-1:0]    cos_acc,
	input  logic signed [wdft_pkg::ACC_W-1:0]    sin_acc,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output wdft_pkg::out_item_t                  out_item
);
	localparam int CW = AW + 1;
	localparam int NW = FW + 1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FETCH = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [AW-1:0] wr_ptr_q, start_q, tap_q;
	logic [CW-1:0] fill_q, len_q;
	logic [wdft_pkg::HOP_W-1:0] hop_q;
	logic [wdft_pkg::FRAME_NUM_W-1:0] frame_q;
	logic [FW-1:0] freq_q;
	logic [NW-1:0] nf_q;
	logic out_valid_q;

	// clamp registers into their working ranges
	logic [CW-1:0] len_c;
	logic [wdft_pkg::HOP_W-1:0] hop_c;
	logic [NW-1:0] nf_c;
	always_comb begin
		if (frame_length < 2) len_c = CW'(2);
		else if (13'(frame_length) > 13'(MAX_FRAME)) len_c = CW'(MAX_FRAME);
		else len_c = CW'(frame_length);
		hop_c = (hop_size == '0) ? wdft_pkg::HOP_W'(1) : hop_size;
		if (freq_count == '0) nf_c = NW'(1);
		else if ({1'b0, freq_count} > 8'(MAX_FREQS)) nf_c = NW'(MAX_FREQS);
		else nf_c = NW'(freq_count);
	end

	logic acc;
	wdft_pkg::cmd_t in_cmd;
	assign in_cmd = wdft_pkg::cmd_t'(in_item.command);
	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign acc = in_valid && in_ready;

	assign weight_we = acc && (in_cmd == wdft_pkg::CMD_WEIGHT)
		&& (13'(in_item.slot) < 13'(MAX_FRAME));
	assign step_we = acc && (in_cmd == wdft_pkg::CMD_STEP)
		&& ({1'b0, in_item.slot} < 11'(MAX_FREQS));
	assign sample_we = acc && (in_cmd == wdft_pkg::CMD_SAMPLE);
	assign wr_ptr = wr_ptr_q;

	// window trigger on this sample
	logic [CW-1:0] fill_n;
	logic [wdft_pkg::HOP_W-1:0] hop_inc;
	logic emit;
	always_comb begin
		fill_n = (fill_q < CW'(MAX_FRAME)) ? fill_q + 1'b1 : fill_q;
		hop_inc = hop_q + 1'b1;
		emit = 1'b0;
		if (fill_n >= len_c) emit = (fill_q < len_c) || (hop_inc >= hop_c);
	end

	logic last_tap;
	assign last_tap = ({1'b0, tap_q} == len_q - 1'b1);

	assign cmd.clear = (state_q == ST_FETCH);
	assign cmd.issue = (state_q == ST_RUN);
	assign tap = tap_q;
	assign ring_pos = start_q + tap_q;
	assign freq_idx = freq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wr_ptr_q <= '0; fill_q <= '0; hop_q <= '0; frame_q <= '0;
			tap_q <= '0; freq_q <= '0; start_q <= '0; len_q <= '0; nf_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a waiting result leaves; in the output state a new one may replace it
			if (out_valid_q && out_ready && state_q != ST_OUT) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (sample_we) begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
						fill_q <= fill_n;
						if (fill_n >= len_c) hop_q <= emit ? '0 : hop_inc;
						if (emit) begin
							start_q <= wr_ptr_q + 1'b1 - len_c[AW-1:0];
							len_q <= len_c;
							nf_q <= nf_c;
							freq_q <= '0;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					tap_q <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					tap_q <= tap_q + 1'b1;
					if (last_tap) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!busy) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						if ({1'b0, freq_q} == nf_q - 1'b1) begin
							frame_q <= frame_q + 1'b1;
							state_q <= ST_IDLE;
						end else begin
							freq_q <= freq_q + 1'b1;
							state_q <= ST_FETCH;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_item.frame_number <= frame_q;
			out_item.freq_number <= wdft_pkg::FREQ_NUM_W'(freq_q);
			out_item.cos_sum <= cos_acc;
			out_item.sin_sum <= sin_acc;
			out_item.last <= ({1'b0, freq_q} == nf_q - 1'b1);
		end
	end
	assign out_valid = out_valid_q;
endmodule

@@ sv/windowed_dft_bank.sv @@
// windowed_dft_bank: top level, configuration registers and the controller/datapath pair
// depends on wdft_pkg, wdft_ctrl, wdft_datapath and wdft_ram
// Load and sample items are accepted while no window is in progress and no result waits. After a sample
// completes a window the block accepts no items until its last result has been transferred:
// each frequency is worked on the single shared multiply-accumulate unit, one tap per cycle from
// the ring and weight memories, and the frequencies of a window are worked one after another.
// Results leave through a one-entry output register.
module windowed_dft_bank #(
	parameter int MAX_FRAME       = wdft_pkg::MAX_FRAME_DEF,
	parameter int MAX_FREQS       = wdft_pkg::MAX_FREQS_DEF,
	parameter int SINE_INDEX_BITS = wdft_pkg::SINE_INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  wdft_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output wdft_pkg::out_item_t           out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wdft_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wdft_pkg::FRAME_LEN_W-1:0] cfg_data
);
	localparam int AW = $clog2(MAX_FRAME);
	localparam int FW = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1;

	logic [wdft_pkg::FRAME_LEN_W-1:0] frame_length_q;
	logic [wdft_pkg::HOP_W-1:0] hop_size_q;
	logic [wdft_pkg::FREQ_CNT_W-1:0] freq_count_q;

	// configuration register transfer
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= 11'd1024;
			hop_size_q <= 11'd512;
			freq_count_q <= 7'd64;
		end else if (cfg_valid) begin
			case (wdft_pkg::reg_idx_t'(cfg_index))
				wdft_pkg::REG_FRAME_LEN: frame_length_q <= cfg_data;
				wdft_pkg::REG_HOP: hop_size_q <= cfg_data;
				wdft_pkg::REG_FREQ_CNT: freq_count_q <= cfg_data[wdft_pkg::FREQ_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	logic weight_we, step_we, sample_we, busy;
	logic [AW-1:0] wr_ptr, tap, ring_pos;
	logic [FW-1:0] freq_idx;
	wdft_pkg::dp_cmd_t cmd;
	logic signed [wdft_pkg::ACC_W-1:0] cos_acc, sin_acc;

	wdft_ctrl #(.MAX_FRAME(MAX_FRAME), .MAX_FREQS(MAX_FREQS)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_item(in_data),
		.frame_length(frame_length_q), .hop_size(hop_size_q), .freq_count(freq_count_q),
		.weight_we, .step_we, .sample_we, .wr_ptr, .cmd, .tap, .ring_pos, .freq_idx,
		.busy, .cos_acc, .sin_acc, .out_valid, .out_ready, .out_item(out_data));

	wdft_datapath #(.MAX_FRAME(MAX_FRAME), .MAX_FREQS(MAX_FREQS),
			.SINE_INDEX_BITS(SINE_INDEX_BITS)) u_dp (
		.clk, .arst_n, .in_item(in_data), .weight_we, .step_we, .sample_we, .wr_ptr,
		.cmd, .tap, .ring_pos, .freq_idx, .cos_acc, .sin_acc, .busy);
endmodule

@@ sv/wdft_checker.sv @@
// wdft_checker: port-level assertions for windowed_dft_bank, bound to the top level
// depends on wdft_pkg
module wdft_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input wdft_pkg::out_item_t out_data
);
	// a pending result holds until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a result that is not last is followed by the next frequency
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last ##1 out_valid && $changed(out_data.freq_number)
		|-> out_data.freq_number == $past(out_data.freq_number) + 1'b1)
		else $error("frequency order broken");

	// no input taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted during a window");

	// first frequency of a window is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last ##1 out_valid && $changed(out_data)
		|-> out_data.freq_number == '0)
		else $error("window did not start at frequency zero");
endmodule

bind windowed_dft_bank wdft_checker u_wdft_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data(out_data));

@@ tb/windowed_dft_bank_test.sv @@
// windowed_dft_bank_test: self-checking testbench for the windowed dft bank
// depends on wdft_pkg and windowed_dft_bank; a scoreboard class predicts every window
// while plain tasks drive the item and register channels; item and result traffic has random gaps
`timescale 1ns / 1ps

import wdft_pkg::*;

// holds a shadow copy of the tables and counters and the queue of pending results
class dft_scoreboard;
	logic signed [15:0] ring [1024];
	logic [15:0]        weights [1024];
	logic [23:0]        steps [64];
	int                 wr_ptr;
	int                 fill;
	int                 hop_cnt;
	logic [15:0]        frame_ctr;
	logic [10:0]        frame_len;
	logic [10:0]        hop_len;
	logic [6:0]         nfreq;
	int                 quarter_wave [257];
	out_item_t          pending_results [$];
	int                 errors;
	int                 checked;
	int                 windows;

	function new();
		longint unsigned x, x2, term, pos, neg, s;
		int m, k;
		wr_ptr = 0;
		fill = 0;
		hop_cnt = 0;
		frame_ctr = '0;
		frame_len = 11'd1024;
		hop_len = 11'd512;
		nfreq = 7'd64;
		errors = 0;
		checked = 0;
		windows = 0;
		// quarter wave by integer taylor series in q30, rounded to q15
		for (m = 0; m <= 256; m++) begin
			x = (longint'(m) * 64'd3373259426) / 64'd512;
			x2 = (x * x) >> 30;
			term = x;
			pos = x;
			neg = 0;
			for (k = 1; k <= 7; k++) begin
				term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) neg += term;
				else pos += term;
			end
			s = (pos > neg) ? pos - neg : 0;
			s = (s + 16384) >> 15;
			if (s > 32767) s = 32767;
			quarter_wave[m] = int'(s);
		end
	endfunction

	function int trig(int idx);
		int q, r, v;
		idx = idx & 1023;
		q = idx / 256;
		r = idx % 256;
		v = (q % 2 == 1) ? quarter_wave[256 - r] : quarter_wave[r];
		return (q >= 2) ? -v : v;
	endfunction

	function void set_reg(reg_idx_t idx, logic [10:0] val);
		case (idx)
			REG_FRAME_LEN: frame_len = val;
			REG_HOP:       hop_len = val;
			REG_FREQ_CNT:  nfreq = val[6:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return pending_results.size();
	endfunction

	// one accepted input item: update tables, maybe correlate a full window
	function void note_input(in_item_t it);
		int len, hop, nf, prev, start, n, k, idx;
		bit fire;
		longint p, v;
		longint unsigned ph;
		logic [47:0] cacc, sacc;
		out_item_t r;
		fire = 0;
		case (cmd_t'(it.command))
			CMD_WEIGHT: begin
				weights[it.slot] = it.weight;
				return;
			end
			CMD_STEP: begin
				if (it.slot < 64) steps[it.slot] = it.phase_step;
				return;
			end
			CMD_SAMPLE: ;
			default: return;
		endcase
		len = (frame_len < 2) ? 2 : ((frame_len > 1024) ? 1024 : frame_len);
		hop = (hop_len == 0) ? 1 : hop_len;
		nf = (nfreq < 1) ? 1 : ((nfreq > 64) ? 64 : nfreq);
		ring[wr_ptr] = it.sample;
		wr_ptr = (wr_ptr + 1) % 1024;
		prev = fill;
		if (fill < 1024) fill++;
		if (fill >= len) begin
			if (prev < len) begin
				fire = 1;
				hop_cnt = 0;
			end else begin
				hop_cnt = (hop_cnt + 1) & 11'h7ff;
				if (hop_cnt >= hop) begin
					fire = 1;
					hop_cnt = 0;
				end
			end
		end
		if (!fire) return;
		start = (wr_ptr + 1024 - len) % 1024;
		for (k = 0; k < nf; k++) begin
			cacc = '0;
			sacc = '0;
			for (n = 0; n < len; n++) begin
				p = longint'(ring[(start + n) % 1024]) * longint'(weights[n]);
				v = p >>> 15;
				ph = longint'(n) * longint'(steps[k]);
				idx = int'(ph[23:14]);
				cacc += 48'(v * longint'(trig(idx + 256)));
				sacc += 48'(v * longint'(trig(idx)));
			end
			r.frame_number = frame_ctr;
			r.freq_number = k[5:0];
			r.cos_sum = cacc;
			r.sin_sum = sacc;
			r.last = (k + 1 == nf);
			pending_results.push_back(r);
		end
		frame_ctr++;
		windows++;
	endfunction

	function void check_result(out_item_t got);
		out_item_t w;
		checked++;
		if (pending_results.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result: frame %0d freq %0d", got.frame_number,
					got.freq_number);
			return;
		end
		w = pending_results.pop_front();
		if (got.frame_number !== w.frame_number || got.freq_number !== w.freq_number ||
				got.cos_sum !== w.cos_sum || got.sin_sum !== w.sin_sum ||
				got.last !== w.last) begin
			errors++;
			if (errors <= 10) begin
				$display("result mismatch: exp frame %0d freq %0d cos %0d sin %0d last %0d",
					w.frame_number, w.freq_number, w.cos_sum, w.sin_sum, w.last);
				$display("                 got frame %0d freq %0d cos %0d sin %0d last %0d",
					got.frame_number, got.freq_number, got.cos_sum, got.sin_sum, got.last);
			end
		end
	endfunction
endclass

module windowed_dft_bank_test;
	localparam int CYCLE_LIMIT = 3000000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [FRAME_LEN_W-1:0] cfg_data = '0;

	dft_scoreboard sb = new();
	bit            gaps_on = 1'b1;
	int            cycles = 0;
	int            items_sent = 0;

	windowed_dft_bank uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one input transfer, after a random gap
	task automatic send_item(in_item_t it);
		int gap;
		bit hit;
		gap = gaps_on ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(negedge clk);
			hit = in_ready;
			@(posedge clk);
		end while (!hit);
		sb.note_input(it);
		items_sent++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [10:0] val);
		bit hit;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			hit = cfg_ready;
			@(posedge clk);
		end while (!hit);
		sb.set_reg(idx, val);
	endtask

	// wait for every result, then let a trailing load settle before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_regs(logic [10:0] len, logic [10:0] hop, logic [10:0] nf);
		write_reg(REG_FRAME_LEN, len);
		write_reg(REG_HOP, hop);
		write_reg(REG_FREQ_CNT, nf);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t make_item(cmd_t c);
		in_item_t it;
		it.command = c;
		it.slot = 10'($urandom);
		it.sample = 16'($urandom);
		it.weight = 16'($urandom);
		it.phase_step = 24'($urandom);
		return it;
	endfunction

	function automatic in_item_t random_item();
		int r;
		in_item_t it;
		r = $urandom_range(0, 99);
		if (r < 70) it = make_item(CMD_SAMPLE);
		else if (r < 82) it = make_item(CMD_WEIGHT);
		else if (r < 95) begin
			it = make_item(CMD_STEP);
			if ($urandom_range(0, 3) != 0) it.slot = 10'($urandom_range(0, 63));
		end else it = make_item(CMD_NONE);
		return it;
	endfunction

	// result side with random stalls
	initial begin
		int stall;
		bit hit;
		out_item_t got;
		@(posedge arst_n);
		forever begin
			stall = gaps_on ? $urandom_range(0, 18) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				hit = out_valid;
				got = out_data;
				@(posedge clk);
			end while (!hit);
			sb.check_result(got);
		end
	end

	// stimulus
	initial begin
		in_item_t it;
		int i, ph, n;
		logic [15:0] start_frame;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest window, hop of one, all frequencies: every sample once two are held yields 64 results
		set_regs(11'd0, 11'd0, 11'd127);

		// fill the weights used by windows up to 64 taps and every step, extremes first
		for (i = 0; i < 64; i++) begin
			it = make_item(CMD_WEIGHT);
			it.slot = 10'(i);
			if (i == 0) it.weight = 16'd0;
			else if (i == 1) it.weight = 16'd32768;
			else if (i == 2) it.weight = 16'hffff;
			send_item(it);
		end
		for (i = 0; i < 64; i++) begin
			it = make_item(CMD_STEP);
			it.slot = 10'(i);
			if (i == 0) it.phase_step = 24'd0;
			else if (i == 1) it.phase_step = 24'hffffff;
			send_item(it);
		end

		// directed: ignored slot, unknown command, sample extremes
		it = make_item(CMD_STEP);
		it.slot = 10'd1023;
		send_item(it);
		it = make_item(CMD_NONE);
		send_item(it);
		for (i = 0; i < 14; i++) begin
			it = make_item(CMD_SAMPLE);
			case (i % 4)
				0: it.sample = -16'sd32768;
				1: it.sample = 16'sd32767;
				2: it.sample = 16'sd0;
				default: ;
			endcase
			send_item(it);
		end
		drain();

		// random phases over assorted window shapes
		for (ph = 0; ph < 6; ph++) begin
			gaps_on = (ph != 3);
			if (ph == 0) set_regs(11'd1, 11'd0, 11'd0);
			else set_regs(11'($urandom_range(2, 48)), 11'($urandom_range(1, 16)),
				11'($urandom_range(1, 8)));
			n = $urandom_range(25, 35);
			for (i = 0; i < n; i++) begin
				send_item(random_item());
				// hold off once mid-phase until the block has caught up
				if (ph == 2 && i == n / 2) begin
					in_valid <= 1'b0;
					while (sb.pending() != 0) @(posedge clk);
				end
			end
			drain();
		end
		gaps_on = 1'b1;

		// widest loaded window, all frequencies: stream samples until one window fires
		set_regs(11'd64, 11'd1, 11'd127);
		start_frame = sb.frame_ctr;
		while (sb.frame_ctr == start_frame) begin
			it = make_item(CMD_SAMPLE);
			send_item(it);
		end
		drain();

		$display("covered %0d input items, %0d windows, %0d results checked", items_sent,
			sb.windows, sb.checked);
		$display("windows of 2 to 64 taps with 1 to 64 frequencies, hop 1 to 16");
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
